[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ILH_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ILH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ilh_pkg.sv]
package ilh_pkg;

    localparam int CMD_W     = 2;
    localparam int DEV_W     = 32;
    localparam int SEC_W     = 48;
    localparam int TIME_W    = 64;
    localparam int SEL_W     = 7;
    localparam int STAT_W    = 3;
    localparam int BIDX_W    = 7;
    localparam int COUNT_W   = 64;
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 136;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_DONE  = 2'd1,
        CMD_READ  = 2'd2
    } ilh_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_STORED  = 3'd0,
        STAT_DROPPED = 3'd1,
        STAT_COUNTED = 3'd2,
        STAT_NOMATCH = 3'd3,
        STAT_BINREAD = 3'd4
    } ilh_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STORE,
        ST_DELTA,
        ST_BIN,
        ST_HREAD,
        ST_HUPD,
        ST_RESP
    } ilh_state_t;

    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [SEC_W-1:0]  sec;
        logic [TIME_W-1:0] start;
    } ilh_entry_t;

    typedef struct packed {
        logic s_ready;
        logic tab_rd;
        logic tab_we;
        logic hist_re;
        logic hist_we;
        logic bin_start;
        logic out_load;
    } ilh_ctrl_t;

endpackage

[src/io_latency_log_histogram.sv]
// Request latency histogram. Each request carries a command in s_tuser: start stores
// its timestamp under the key (device, sector), done looks the key up, frees the entry
// and counts now - start in one of BIN_TOTAL log2-linear bins, read returns one bin's
// count; an unused command is swallowed with no response. Every other request yields
// one response with its status in m_tuser. Requests are handled one at a time. Start and
// done walk the key table one entry per cycle through its single read port: a start
// walks the whole table on a new key and stops at the matching entry on a match; a
// done stops at its match and walks the whole table on a miss, and a matched done
// then goes through the subtract, the six-step leading-zero shifter and the histogram
// read-modify-write. Counters start at zero after reset with no clearing pass; a low
// m_tready holds the response, and the block then waits with the next response until
// it is taken.
`include "assert_macros.svh"

module io_latency_log_histogram import ilh_pkg::*; #(
    parameter int TABLE_ENTRIES = 256,
    parameter int BIN_TOTAL     = 100
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // device_id[31:0], sector_number[79:32], time_ns[143:80], bin_to_read[150:144]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // bin_index[6:0], latency_ns[70:7], bin_count[134:71]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [STAT_W-1:0]    m_tuser
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCAN_W = $clog2(TABLE_ENTRIES + 1);
    localparam int BIN_W  = (BIN_TOTAL > 1) ? $clog2(BIN_TOTAL) : 1;

    ilh_state_t state_reg, state_next;
    ilh_ctrl_t  ctl;

    logic [CMD_W-1:0]   cmd_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic [SEC_W-1:0]   sec_reg;
    logic [TIME_W-1:0]  time_reg;

    ilh_entry_t         tab_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] entry_valid_reg;
    ilh_entry_t         rd_entry_reg;
    logic               rd_valid_reg;

    logic [SCAN_W-1:0]  scan_cnt_reg;
    logic               cmp_live_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [TIME_W-1:0]  hit_start_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic [COUNT_W-1:0] hist_mem [BIN_TOTAL];
    logic [BIN_TOTAL-1:0] hist_valid_reg;
    logic [COUNT_W-1:0] hist_rd_reg;
    logic               hist_rd_valid_reg;

    logic [TIME_W-1:0]  delta_reg;
    logic [BIN_W-1:0]   bin_reg;
    logic [STAT_W-1:0]  res_status_reg;
    logic [COUNT_W-1:0] res_count_reg;

    logic               m_valid_reg;
    logic [STAT_W-1:0]  m_status_reg;
    logic [BIDX_W-1:0]  m_bin_reg;
    logic [TIME_W-1:0]  m_lat_reg;
    logic [COUNT_W-1:0] m_count_reg;

    logic [SEL_W-1:0]   sel_in;
    logic [BIN_W-1:0]   sel_clamped;
    logic               scan_issue;
    logic               scan_end;
    logic               cmp_valid;
    logic               key_match;
    logic [IDX_W-1:0]   wr_idx;
    logic [TIME_W-1:0]  delta_calc;
    logic [COUNT_W-1:0] count_cur;
    logic [COUNT_W-1:0] count_new;
    logic               bin_done;
    logic [BIN_W-1:0]   bin_calc;
    logic               is_done_cmd;
    logic               counted;

    always_comb begin
        sel_in      = s_tdata[150:144];
        sel_clamped = ({1'b0, sel_in} >= 8'(BIN_TOTAL)) ? BIN_W'(BIN_TOTAL - 1)
                                                        : BIN_W'(sel_in);
        scan_issue  = (scan_cnt_reg < SCAN_W'(TABLE_ENTRIES));
        scan_end    = !cmp_live_reg && (scan_cnt_reg == SCAN_W'(TABLE_ENTRIES));
        cmp_valid   = rd_valid_reg;
        key_match   = cmp_live_reg && cmp_valid && (rd_entry_reg.dev == dev_reg)
                      && (rd_entry_reg.sec == sec_reg);
        wr_idx      = hit_reg ? hit_idx_reg : free_idx_reg;
        delta_calc  = time_reg - hit_start_reg;
        is_done_cmd = (cmd_reg == CMD_DONE);
        count_cur   = hist_rd_valid_reg ? hist_rd_reg : '0;
        count_new   = is_done_cmd ? count_cur + 64'd1 : count_cur;
        counted     = (res_status_reg == STAT_COUNTED);
    end

    ilh_bin_unit #(
        .BIN_TOTAL(BIN_TOTAL),
        .BIN_W    (BIN_W)
    ) u_bin (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (ctl.bin_start),
        .delta  (delta_calc),
        .done   (bin_done),
        .bin    (bin_calc)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        CMD_START, CMD_DONE: state_next = ST_SCAN;
                        CMD_READ:            state_next = ST_HREAD;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (key_match) begin
                    state_next = is_done_cmd ? ST_DELTA : ST_STORE;
                end else if (scan_end) begin
                    state_next = is_done_cmd ? ST_RESP : ST_STORE;
                end
            end
            ST_STORE: state_next = ST_RESP;
            ST_DELTA: state_next = ST_BIN;
            ST_BIN: begin
                if (bin_done) begin
                    state_next = ST_HREAD;
                end
            end
            ST_HREAD: state_next = ST_HUPD;
            ST_HUPD:  state_next = ST_RESP;
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:  ctl.s_ready   = 1'b1;
            ST_SCAN:  ctl.tab_rd    = scan_issue;
            ST_STORE: ctl.tab_we    = hit_reg || free_found_reg;
            ST_DELTA: ctl.bin_start = 1'b1;
            ST_BIN:   ;
            ST_HREAD: ctl.hist_re   = 1'b1;
            ST_HUPD:  ctl.hist_we   = is_done_cmd;
            ST_RESP:  ctl.out_load  = !m_valid_reg || m_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // capture request
    always_ff @(posedge aclk) begin
        if (ctl.s_ready && s_tvalid) begin
            cmd_reg  <= s_tuser;
            dev_reg  <= s_tdata[31:0];
            sec_reg  <= s_tdata[79:32];
            time_reg <= s_tdata[143:80];
            bin_reg  <= sel_clamped;
        end else if (bin_done) begin
            bin_reg <= bin_calc;
        end
        if (state_reg == ST_DELTA) begin
            delta_reg <= delta_calc;
        end
    end

    // key table
    always_ff @(posedge aclk) begin
        if (ctl.tab_we) begin
            tab_mem[wr_idx] <= '{dev: dev_reg, sec: sec_reg, start: time_reg};
        end
        if (ctl.tab_rd) begin
            rd_entry_reg <= tab_mem[scan_cnt_reg[IDX_W-1:0]];
            rd_valid_reg <= entry_valid_reg[scan_cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (ctl.tab_we) begin
            entry_valid_reg[wr_idx] <= 1'b1;
        end else if (state_reg == ST_DELTA) begin
            entry_valid_reg[hit_idx_reg] <= 1'b0;
        end
    end

    // scan walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg   <= '0;
            cmp_live_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (ctl.s_ready && s_tvalid) begin
            scan_cnt_reg   <= '0;
            cmp_live_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            cmp_live_reg <= scan_issue && !key_match;
            if (scan_issue) begin
                scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
            end
            if (key_match) begin
                hit_reg <= 1'b1;
            end
            if (cmp_live_reg && !cmp_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end else begin
            cmp_live_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        if (state_reg == ST_SCAN && key_match) begin
            hit_idx_reg   <= cmp_idx_reg;
            hit_start_reg <= rd_entry_reg.start;
        end
        if (state_reg == ST_SCAN && cmp_live_reg && !cmp_valid && !free_found_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    // histogram
    always_ff @(posedge aclk) begin
        if (ctl.hist_we) begin
            hist_mem[bin_reg] <= count_new;
        end
        if (ctl.hist_re) begin
            hist_rd_reg <= hist_mem[bin_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_valid_reg    <= '0;
            hist_rd_valid_reg <= 1'b0;
        end else begin
            if (ctl.hist_we) begin
                hist_valid_reg[bin_reg] <= 1'b1;
            end
            if (ctl.hist_re) begin
                hist_rd_valid_reg <= hist_valid_reg[bin_reg];
            end
        end
    end

    // response fields
    always_ff @(posedge aclk) begin
        if (ctl.s_ready && s_tvalid) begin
            res_count_reg <= '0;
        end else if (state_reg == ST_HUPD) begin
            res_count_reg <= count_new;
        end
        priority if (state_reg == ST_STORE) begin
            res_status_reg <= (hit_reg || free_found_reg) ? STAT_STORED : STAT_DROPPED;
        end else if (state_reg == ST_SCAN && scan_end && !key_match) begin
            res_status_reg <= STAT_NOMATCH;
        end else if (state_reg == ST_HUPD) begin
            res_status_reg <= is_done_cmd ? STAT_COUNTED : STAT_BINREAD;
        end else begin
            res_status_reg <= res_status_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_status_reg <= res_status_reg;
            m_bin_reg    <= (counted || res_status_reg == STAT_BINREAD)
                            ? BIDX_W'(bin_reg) : '0;
            m_lat_reg    <= counted ? delta_reg : '0;
            m_count_reg  <= res_count_reg;
        end
    end

    assign s_tready = ctl.s_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_lat_reg, m_bin_reg};

    `ILH_ASSERT_IMPLY(a_bin_done_in_bin, aclk, aresetn, bin_done, state_reg == ST_BIN, "bin unit finished outside its wait state")
    `ILH_ASSERT_NEXT(a_read_to_hread, aclk, aresetn, s_tvalid && s_tready && s_tuser == CMD_READ, state_reg == ST_HREAD, "read request did not go to histogram read")
    `ILH_ASSERT_IMPLY(a_rise_from_resp, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_RESP), "response raised outside response state")
    `ILH_ASSERT_IMPLY(a_latency_zero, aclk, aresetn, m_valid_reg && m_status_reg != STAT_COUNTED, m_lat_reg == '0, "latency set on a response that counted nothing")
    `ILH_ASSERT_IMPLY(a_scan_bound, aclk, aresetn, state_reg == ST_SCAN, scan_cnt_reg <= SCAN_W'(TABLE_ENTRIES), "table walk ran past the last entry")

endmodule

[src/ilh_bin_unit.sv]
module ilh_bin_unit import ilh_pkg::*; #(
    parameter int BIN_TOTAL = 100,
    parameter int BIN_W     = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TIME_W-1:0] delta,
    output logic              done,
    output logic [BIN_W-1:0]  bin
);

    localparam int STEPS = 6;

    logic [TIME_W-1:0] v_reg;
    logic [5:0]        lz_reg;
    logic [2:0]        step_reg;
    logic              busy_reg;
    logic              calc_reg;
    logic              done_reg;
    logic [BIN_W-1:0]  bin_reg;

    logic [5:0]        shamt;
    logic [TIME_W-1:0] top_mask;
    logic              top_zero;
    logic [5:0]        lg;
    logic [11:0]       mant;
    logic [13:0]       prod;
    logic [7:0]        idx;
    logic [BIN_W-1:0]  bin_clamped;

    always_comb begin
        shamt       = 6'(7'd32 >> step_reg);
        top_mask    = ~({TIME_W{1'b1}} >> shamt);
        top_zero    = ((v_reg & top_mask) == '0);
        lg          = 6'd63 - lz_reg;
        mant        = {lg, v_reg[62:57]};
        prod        = {2'b00, mant} * 14'd3;
        idx         = prod[13:6];
        bin_clamped = (idx >= 8'(BIN_TOTAL)) ? BIN_W'(BIN_TOTAL - 1) : BIN_W'(idx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            calc_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == 3'(STEPS - 1)) begin
                busy_reg <= 1'b0;
                calc_reg <= 1'b1;
            end else if (calc_reg) begin
                calc_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // normalise: shift out leading zeros, halving the step each cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg    <= delta;
            lz_reg   <= '0;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 3'd1;
            if (top_zero) begin
                v_reg  <= v_reg << shamt;
                lz_reg <= lz_reg + shamt;
            end
        end
        if (calc_reg) begin
            bin_reg <= bin_clamped;
        end
    end

    assign done = done_reg;
    assign bin  = bin_reg;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ilh_pkg::*;

    localparam int TABLE_ENTRIES = 256;
    localparam int BIN_TOTAL     = 100;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DEV_W-1:0]  dev;
        logic [SEC_W-1:0]  sec;
        logic [TIME_W-1:0] tns;
        logic [SEL_W-1:0]  sel;
    } req_t;

    typedef struct packed {
        ilh_status_t        status;
        logic [BIDX_W-1:0]  bin;
        logic [TIME_W-1:0]  lat;
        logic [COUNT_W-1:0] cnt;
    } resp_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    io_latency_log_histogram #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .BIN_TOTAL    (BIN_TOTAL)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // shadow of the key table and the histogram
    logic               key_live [TABLE_ENTRIES];
    logic [DEV_W-1:0]   key_dev  [TABLE_ENTRIES];
    logic [SEC_W-1:0]   key_sec  [TABLE_ENTRIES];
    logic [TIME_W-1:0]  key_start[TABLE_ENTRIES];
    logic [COUNT_W-1:0] bin_tally[BIN_TOTAL];

    req_t  req_backlog[$];
    resp_t awaited_resp[$];
    req_t  cur;
    resp_t want;
    logic  s_fire     = 1'b0;
    bit    all_queued = 1'b0;
    int    send_gap   = 0;
    int    stall_left = 0;
    int    errors     = 0;

    initial begin
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            key_live[k]  = 1'b0;
            key_dev[k]   = '0;
            key_sec[k]   = '0;
            key_start[k] = '0;
        end
        for (int k = 0; k < BIN_TOTAL; k++) begin
            bin_tally[k] = '0;
        end
    end

    function automatic logic [BIDX_W-1:0] log_bin(input logic [TIME_W-1:0] d);
        logic [63:0] lg;
        logic [63:0] frac;
        logic [63:0] idx;
        int k;
        lg = '0;
        if (d == 0) begin
            return '0;
        end
        for (k = 0; k < TIME_W; k++) begin
            if (d[k]) begin
                lg = 64'(k);
            end
        end
        if (lg >= 6) begin
            frac = (d >> (lg - 6)) & 64'd63;
        end else begin
            frac = (d - (64'd1 << lg)) << (6 - lg);
        end
        idx = (lg * 64 + frac) * 3 / 64;
        if (idx >= BIN_TOTAL) begin
            idx = 64'(BIN_TOTAL - 1);
        end
        return idx[BIDX_W-1:0];
    endfunction

    function automatic void track_request(input req_t r);
        int slot;
        int k;
        logic [TIME_W-1:0] delta;
        logic [BIDX_W-1:0] b;
        resp_t e;
        e = '0;
        slot = -1;
        for (k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (key_live[k] && key_dev[k] == r.dev && key_sec[k] == r.sec) begin
                slot = k;
            end
        end
        case (r.cmd)
            CMD_START: begin
                if (slot < 0) begin
                    for (k = TABLE_ENTRIES - 1; k >= 0; k--) begin
                        if (!key_live[k]) begin
                            slot = k;
                        end
                    end
                end
                if (slot < 0) begin
                    e.status = STAT_DROPPED;
                end else begin
                    key_live[slot]  = 1'b1;
                    key_dev[slot]   = r.dev;
                    key_sec[slot]   = r.sec;
                    key_start[slot] = r.tns;
                    e.status = STAT_STORED;
                end
            end
            CMD_DONE: begin
                if (slot < 0) begin
                    e.status = STAT_NOMATCH;
                end else begin
                    key_live[slot] = 1'b0;
                    delta = r.tns - key_start[slot];
                    b = log_bin(delta);
                    bin_tally[b] = bin_tally[b] + 64'd1;
                    e.status = STAT_COUNTED;
                    e.bin    = b;
                    e.lat    = delta;
                    e.cnt    = bin_tally[b];
                end
            end
            CMD_READ: begin
                b = (r.sel >= BIN_TOTAL) ? BIDX_W'(BIN_TOTAL - 1) : r.sel;
                e.status = STAT_BINREAD;
                e.bin    = b;
                e.cnt    = bin_tally[b];
            end
            default: begin
                return;
            end
        endcase
        awaited_resp.push_back(e);
    endfunction

    function automatic bit calm_phase();
        return all_queued && (req_backlog.size() < 60);
    endfunction

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_fire) begin
                if (send_gap == 0 && !calm_phase() && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 6);
                end
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    cur = req_backlog.pop_front();
                    s_tuser  <= cur.cmd;
                    s_tdata  <= {1'b0, cur.sel, cur.tns, cur.sec, cur.dev};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left == 0 && !calm_phase() && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (awaited_resp.size() == 0) begin
                    $display("%0t: unexpected response, expected none, actual status %0d data %h",
                             $time, m_tuser, m_tdata);
                    errors++;
                end else begin
                    want = awaited_resp.pop_front();
                    if (m_tuser !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[6:0] !== want.bin) begin
                        $display("%0t: bin_index expected %0d actual %0d",
                                 $time, want.bin, m_tdata[6:0]);
                        errors++;
                    end
                    if (m_tdata[70:7] !== want.lat) begin
                        $display("%0t: latency_ns expected %h actual %h",
                                 $time, want.lat, m_tdata[70:7]);
                        errors++;
                    end
                    if (m_tdata[134:71] !== want.cnt) begin
                        $display("%0t: bin_count expected %h actual %h",
                                 $time, want.cnt, m_tdata[134:71]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                track_request(cur);
            end
        end
    end

    logic [TIME_W-1:0] now_ns;
    logic [DEV_W-1:0]  pool_dev[8];
    logic [SEC_W-1:0]  pool_sec[8];
    logic [DEV_W-1:0]  fill_dev[262];
    logic [SEC_W-1:0]  fill_sec[262];

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_req(input logic [CMD_W-1:0] c, input logic [DEV_W-1:0] d,
                            input logic [SEC_W-1:0] s, input logic [TIME_W-1:0] t,
                            input logic [SEL_W-1:0] b);
        req_t r;
        r.cmd = c;
        r.dev = d;
        r.sec = s;
        r.tns = t;
        r.sel = b;
        req_backlog.push_back(r);
    endtask

    task automatic step_clock();
        int sh;
        sh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(24, 63);
        now_ns = now_ns + (rand64() >> sh);
    endtask

    task automatic random_mix(input int n);
        int i;
        int pick;
        int roll;
        logic [TIME_W-1:0] t;
        logic [SEC_W-1:0]  s;
        logic [SEL_W-1:0]  b;
        for (i = 0; i < n; i++) begin
            step_clock();
            pick = $urandom_range(0, 7);
            roll = $urandom_range(0, 99);
            t = ($urandom_range(0, 19) == 0) ? rand64() : now_ns;
            s = SEC_W'(rand64());
            b = SEL_W'($urandom_range(0, 127));
            if (roll < 40) begin
                push_req(CMD_START, pool_dev[pick], pool_sec[pick], t, b);
            end else if (roll < 75) begin
                push_req(CMD_DONE, pool_dev[pick], pool_sec[pick], t, b);
            end else if (roll < 82) begin
                push_req(CMD_DONE, $urandom, s, t, b);
            end else if (roll < 96) begin
                push_req(CMD_READ, $urandom, s, rand64(), b);
            end else begin
                push_req(CMD_UNUSED, $urandom, s, rand64(), b);
            end
        end
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || s_tvalid || awaited_resp.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        int k;
        now_ns = rand64();
        for (k = 0; k < 8; k++) begin
            pool_dev[k] = $urandom;
            pool_sec[k] = SEC_W'(rand64());
        end

        push_req(CMD_READ, '0, '0, '0, 7'd0);
        push_req(CMD_READ, '1, '1, '1, 7'd99);
        push_req(CMD_READ, '0, '0, '0, 7'd127);
        push_req(CMD_START, '0, '0, '0, 7'd0);
        push_req(CMD_DONE, '0, '0, '0, 7'd0);
        push_req(CMD_READ, '0, '0, '0, 7'd0);
        push_req(CMD_START, '1, '1, '1, 7'd127);
        push_req(CMD_DONE, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE, 7'd127);
        push_req(CMD_READ, '0, '0, '0, 7'd100);
        push_req(CMD_START, 32'h0000_0008, 48'h0000_0010_0000, 64'd1000, 7'd0);
        push_req(CMD_START, 32'h0000_0008, 48'h0000_0010_0000, 64'd2000, 7'd0);
        push_req(CMD_DONE, 32'h0000_0008, 48'h0000_0010_0000, 64'd2001, 7'd0);
        push_req(CMD_DONE, 32'h0000_0008, 48'h0000_0010_0000, 64'd3000, 7'd0);
        push_req(CMD_START, 32'h0000_0001, 48'h0000_0000_0001, 64'd0, 7'd0);
        push_req(CMD_DONE, 32'h0000_0001, 48'h0000_0000_0001, 64'd5, 7'd0);
        push_req(CMD_START, 32'h0000_0002, 48'h8000_0000_0000, 64'd0, 7'd0);
        push_req(CMD_DONE, 32'h0000_0002, 48'h8000_0000_0000, 64'd63, 7'd0);
        push_req(CMD_START, 32'h8000_0000, 48'h0000_0000_0002, 64'd0, 7'd0);
        push_req(CMD_DONE, 32'h8000_0000, 48'h0000_0000_0002, 64'd64, 7'd0);
        push_req(CMD_UNUSED, '1, '1, '1, '1);
        push_req(CMD_DONE, '1, '0, '1, 7'd0);
        push_req(CMD_READ, '0, '0, '0, 7'd1);

        random_mix(150);

        // hold the sender until the block has answered everything
        wait_drained();

        // fill the table past its capacity, then free part of it
        for (k = 0; k < 262; k++) begin
            fill_dev[k] = $urandom;
            fill_sec[k] = SEC_W'(rand64());
            step_clock();
            push_req(CMD_START, fill_dev[k], fill_sec[k], now_ns,
                     SEL_W'($urandom_range(0, 127)));
        end
        for (k = 0; k < 40; k++) begin
            step_clock();
            push_req(CMD_DONE, fill_dev[k], fill_sec[k], now_ns,
                     SEL_W'($urandom_range(0, 127)));
        end

        random_mix(100);
        all_queued = 1'b1;

        wait_drained();
        repeat (300) @(posedge aclk);
        if (errors == 0 && awaited_resp.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/ilh_pkg.sv
src/ilh_bin_unit.sv
src/io_latency_log_histogram.sv
sim/tb.sv
